FILE: hdl/lruc_pkg.sv
// Package for the LRU key-value cache: shared types and constants.
`default_nettype none

package lruc_pkg;

  // Operation code carried by each input item.
  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lruc_cmd_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;

  // Per-cycle request broadcast to every entry lane.
  typedef struct packed {
    logic              touch;   // key hit: make the hit entry most recent
    logic              insert;  // put miss: place key in the selected slot
    logic              put;     // item is a put
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } lruc_req_t;

endpackage

`default_nettype wire

FILE: hdl/lruc_entry.sv
// One entry lane of the LRU cache: key, value, valid bit and recency rank.
`default_nettype none

module lruc_entry #(
  parameter int unsigned RANK_W = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lruc_pkg::lruc_req_t         req,
  input  wire logic [RANK_W-1:0]           hit_rank,
  input  wire logic                        evict_en,
  input  wire logic [RANK_W-1:0]           evict_rank,
  input  wire logic                        ins_sel,
  output logic                             hit,
  output logic                             evict,
  output logic                             valid,
  output logic [RANK_W-1:0]                rank,
  output logic [lruc_pkg::DATA_W-1:0]      value
);

  logic                          valid_r, valid_nxt;
  logic [RANK_W-1:0]             rank_r, rank_nxt;
  logic [lruc_pkg::DATA_W-1:0]   key_r, key_nxt;
  logic [lruc_pkg::DATA_W-1:0]   value_r, value_nxt;
  logic [RANK_W-1:0]             rank_inc;

  assign hit      = valid_r && (key_r == req.key);
  assign evict    = valid_r && evict_en && (rank_r == evict_rank);
  assign rank_inc = RANK_W'(rank_r + 1'b1);
  assign valid    = valid_r;
  assign rank     = rank_r;
  assign value    = value_r;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (req.touch) begin
      if (hit) begin
        rank_nxt = '0;
        if (req.put) begin
          value_nxt = req.value;
        end
      end else if (valid_r && (rank_r < hit_rank)) begin
        rank_nxt = rank_inc;
      end
    end else if (req.insert) begin
      if (ins_sel) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        key_nxt   = req.key;
        value_nxt = req.value;
      end else if (evict) begin
        valid_nxt = 1'b0;
      end else if (valid_r) begin
        rank_nxt = rank_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
//
//   channel  dir  handshake            payload
//   -------  ---  -------------------  -------------------------------------------
//   in_      in   in_valid/in_ready    in_cmd, in_lookup_key, in_write_value
//   out_     out  out_valid/out_ready  out_found, out_read_value
//   cfg_     in   cfg_wr_en            cfg_wr_data (capacity_limit, 5 bits)
//
// Flow: one item per clock while results are taken. An accepted item is held in the
//   input register; from there it is looked up in all entries at once, the lanes
//   update, and the result lands in the output register.
// Throughput is set by the parallel key compare plus rank update.
// Reset (rst_n low, synchronous): all valid bits and ranks clear, occupancy 0,
//   capacity_limit 16. Key and value storage is not cleared.
// Stalls: when out_ready is low with a result held, the input register holds and
//   in_ready drops once it is also full; nothing is lost or repeated.
`default_nettype none

module lru_key_value_cache_core #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_cmd,
  input  wire logic signed [31:0]          in_lookup_key,
  input  wire logic signed [31:0]          in_write_value,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic signed [31:0]               out_read_value,
  // configuration
  input  wire logic                        cfg_wr_en,
  input  wire logic [lruc_pkg::CAP_W-1:0]  cfg_wr_data
);

  localparam int unsigned RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > lruc_pkg::CAP_W) ? OCC_W : lruc_pkg::CAP_W;
  localparam int unsigned DW     = lruc_pkg::DATA_W;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [lruc_pkg::CAP_W-1:0] cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lruc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Clamp capacity into 1..MAX_ENTRIES.
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_max;
  logic [CMP_W-1:0] eff_cap;

  assign cap_ext = CMP_W'(cap_r);
  assign cap_max = CMP_W'(MAX_ENTRIES);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > cap_max) begin
      eff_cap = cap_max;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register and output register
  // ---------------------------------------------------------------------------
  logic                  in_v_r;
  lruc_pkg::lruc_cmd_t   in_cmd_r;
  logic [DW-1:0]         in_key_r;
  logic [DW-1:0]         in_val_r;
  logic                  out_v_r;
  logic                  out_found_r, out_found_nxt;
  logic [DW-1:0]         out_data_r, out_data_nxt;
  logic                  advance;
  logic                  go;

  assign advance  = !out_v_r || out_ready;
  assign go       = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r <= lruc_pkg::lruc_cmd_t'(in_cmd);
      in_key_r <= $unsigned(in_lookup_key);
      in_val_r <= $unsigned(in_write_value);
    end
    if (go) begin
      out_found_r <= out_found_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_found      = out_found_r;
  assign out_read_value = $signed(out_data_r);

  // ---------------------------------------------------------------------------
  // Entry lanes
  // ---------------------------------------------------------------------------
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic [OCC_W-1:0]        occ_m1;
  logic [MAX_ENTRIES-1:0]  hit_vec;
  logic [MAX_ENTRIES-1:0]  evict_vec;
  logic [MAX_ENTRIES-1:0]  valid_vec;
  logic [MAX_ENTRIES-1:0]  free_vec;
  logic [MAX_ENTRIES-1:0]  ins_vec;
  logic [RANK_W-1:0]       rank_arr [MAX_ENTRIES];
  logic [DW-1:0]           value_arr [MAX_ENTRIES];
  logic [RANK_W-1:0]       hit_rank;
  logic [DW-1:0]           hit_value;
  logic                    any_hit;
  logic                    is_put;
  logic                    evict_en;
  logic                    do_evict;
  lruc_pkg::lruc_req_t     req;

  assign is_put  = (in_cmd_r == lruc_pkg::CMD_PUT);
  assign any_hit = |hit_vec;
  assign occ_m1  = OCC_W'(occ_r - 1'b1);

  // Eviction applies to a put miss once occupancy reaches capacity; the victim
  // is the valid entry whose rank is occupancy-1 (ranks are dense 0..occ-1).
  assign evict_en = go && is_put && !any_hit && (CMP_W'(occ_r) >= eff_cap);
  assign do_evict = |evict_vec;

  // Lowest free slot after eviction.
  assign free_vec = ~valid_vec | evict_vec;
  assign ins_vec  = free_vec & (~free_vec + 1'b1);

  always_comb begin
    req.touch  = go && any_hit;
    req.insert = go && is_put && !any_hit;
    req.put    = is_put;
    req.key    = in_key_r;
    req.value  = in_val_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_lane
      lruc_entry #(
        .RANK_W (RANK_W)
      ) u_entry (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .hit_rank   (hit_rank),
        .evict_en   (evict_en),
        .evict_rank (occ_m1[RANK_W-1:0]),
        .ins_sel    (ins_vec[gi]),
        .hit        (hit_vec[gi]),
        .evict      (evict_vec[gi]),
        .valid      (valid_vec[gi]),
        .rank       (rank_arr[gi]),
        .value      (value_arr[gi])
      );
    end
  endgenerate

  // One-hot select of the hit entry's rank and value.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_rank  = hit_rank  | (rank_arr[i]  & {RANK_W{hit_vec[i]}});
      hit_value = hit_value | (value_arr[i] & {DW{hit_vec[i]}});
    end
  end

  // Result payload
  always_comb begin
    out_found_nxt = any_hit;
    if (is_put) begin
      out_data_nxt = lruc_pkg::PUT_VALUE;
    end else if (any_hit) begin
      out_data_nxt = hit_value;
    end else begin
      out_data_nxt = lruc_pkg::MISS_VALUE;
    end
  end

  // Occupancy: a put miss adds one entry unless it also evicted one.
  always_comb begin
    occ_nxt = occ_r;
    if (req.insert && !do_evict) begin
      occ_nxt = OCC_W'(occ_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(occ_r))
    else $error("occupancy does not match valid entry count");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("key present in more than one entry");

  a_evict_unique: assert property (@(posedge clk) disable iff (!rst_n)
    evict_en |-> $onehot(evict_vec))
    else $error("eviction did not pick exactly one victim");

  a_get_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_put) |=> (occ_r == $past(occ_r)))
    else $error("get changed occupancy");

  a_insert_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    req.insert |-> $onehot(ins_vec))
    else $error("put miss found no free slot");

endmodule

`default_nettype wire

FILE: verif/lruc_tracker.sv
// Watches the cache channels, predicts each reply and compares it with the block's output.
module lruc_tracker
  import lruc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_cmd,
  input  logic [DATA_W-1:0]   in_lookup_key,
  input  logic [DATA_W-1:0]   in_write_value,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_found,
  input  logic [DATA_W-1:0]   out_read_value,
  input  logic                cfg_wr_en,
  input  logic [CAP_W-1:0]    cfg_wr_data,
  output int                  fail_count,
  output int                  outstanding,
  output int                  hit_count
);

  typedef struct {
    logic              found;
    logic [DATA_W-1:0] value;
  } cache_reply_t;

  cache_reply_t replies_due[$];

  // Shadow copy of the store.
  logic [DATA_W-1:0] slot_key   [MAX_ENTRIES];
  logic [DATA_W-1:0] slot_val   [MAX_ENTRIES];
  logic              slot_valid [MAX_ENTRIES];
  int unsigned       slot_rank  [MAX_ENTRIES];
  int unsigned       held;
  logic [CAP_W-1:0]  cap_reg;

  function automatic int unsigned usable_capacity();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > MAX_ENTRIES) c = MAX_ENTRIES;
    return c;
  endfunction

  // Rank 0 is most recent; younger valid entries age by one.
  function automatic void make_newest(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic void insert_key(logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    int oldest;
    int free_slot;
    oldest = -1;
    free_slot = -1;
    if (held >= usable_capacity()) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_valid[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) oldest = i;
      if (oldest >= 0) begin
        slot_valid[oldest] = 1'b0;
        held--;
      end
    end
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (!slot_valid[i] && free_slot < 0) free_slot = i;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_valid[i]) slot_rank[i]++;
    slot_key[free_slot]   = key;
    slot_val[free_slot]   = value;
    slot_valid[free_slot] = 1'b1;
    slot_rank[free_slot]  = 0;
    held++;
  endfunction

  function automatic cache_reply_t predict_reply(lruc_cmd_t op, logic [DATA_W-1:0] key,
                                                 logic [DATA_W-1:0] value);
    cache_reply_t r;
    int s;
    s = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == key && s < 0) s = i;
    r.found = (s >= 0);
    if (op == CMD_GET) begin
      if (s >= 0) begin
        make_newest(s);
        r.value = slot_val[s];
      end else begin
        r.value = MISS_VALUE;
      end
    end else begin
      if (s >= 0) begin
        make_newest(s);
        slot_val[s] = value;
      end else begin
        insert_key(key, value);
      end
      r.value = PUT_VALUE;
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    cache_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = 0;
      end
      held = 0;
      cap_reg = CAP_RESET;
      replies_due.delete();
      fail_count = 0;
      hit_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: found %0b read_value %h", out_found, out_read_value);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, out_found);
            fail_count++;
          end
          if (out_read_value !== want.value) begin
            $error("read_value: expected %h, actual %h", want.value, out_read_value);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) cap_reg = cfg_wr_data;
      if (in_valid && in_ready) begin
        want = predict_reply(lruc_cmd_t'(in_cmd), in_lookup_key, in_write_value);
        if (want.found) hit_count++;
        replies_due.push_back(want);
      end
    end
    outstanding = replies_due.size();
  end

endmodule

FILE: verif/tb.sv
// Top of the LRU key-value cache testbench: clock, reset, stimulus and verdict.
module tb;
  import lruc_pkg::*;

  localparam int unsigned ENTRIES = 16;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_cmd;
  logic [DATA_W-1:0] in_lookup_key;
  logic [DATA_W-1:0] in_write_value;
  logic              out_valid;
  logic              out_ready;
  logic              out_found;
  logic [DATA_W-1:0] out_read_value;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;

  int fail_count;
  int outstanding;
  int hit_count;

  // Knobs shared by the sender and the receiver.
  bit calm;       // no idling at all, used for the closing phase
  bit hold_req;   // ask the receiver for one long hold-off
  int items_sent;

  // Keys drawn per phase; a pool slightly larger than the capacity keeps
  // both hits and evictions frequent.
  logic [DATA_W-1:0] key_pool [32];
  int                pool_n;

  always #4 clk = ~clk;

  lru_key_value_cache_core #(
    .MAX_ENTRIES (ENTRIES)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  lruc_tracker #(
    .MAX_ENTRIES (ENTRIES)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_read_value (out_read_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .hit_count      (hit_count)
  );

  // Receiver: mostly ready, random stall bursts of random length, and one long
  // hold-off on request so the pipeline fills and in_ready drops.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_ready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one item at a falling edge, possibly after an idle burst, and hold it
  // until the rising edge that accepts it.
  task automatic send_op(input lruc_cmd_t op, input logic [DATA_W-1:0] key,
                         input logic [DATA_W-1:0] value);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = op;
    in_lookup_key  = key;
    in_write_value = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait for every reply.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Capacity is only written with the pipeline empty.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = cap;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // One phase of random traffic: ~40% puts, keys mostly from the pool, whose first
  // slots hold the sign and range extremes, the rest fully random (misses).
  task automatic random_phase(input logic [CAP_W-1:0] cap, input int count,
                              input bit with_hold);
    int unsigned usable;
    lruc_cmd_t   op;
    logic [DATA_W-1:0] key;
    usable = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
    pool_n = usable + $urandom_range(1, 8);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = 1'b1;
      op  = ($urandom_range(0, 9) < 4) ? CMD_PUT : CMD_GET;
      key = ($urandom_range(0, 7) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
      send_op(op, key, $urandom);
    end
  endtask

  // Capacity settings: below, at and above the legal range, plus a drop from
  // a full store to a small limit (the store keeps its entries and sheds one
  // per put miss).
  localparam int PHASES = 10;
  localparam logic [CAP_W-1:0] CAP_PLAN [PHASES] =
    '{5'd3, 5'd0, 5'd31, 5'd1, 5'd16, 5'd5, 5'd12, 5'd2, 5'd9, 5'd16};

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_GET;
    in_lookup_key  = '0;
    in_write_value = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    items_sent     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: lookup on an empty store, extreme keys and values, update on
    // hit, and lookups that hit and miss. Capacity still at its reset value.
    send_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_op(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_op(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_op(CMD_GET, 32'h0000_0005, 32'h0000_0000);
    send_op(CMD_PUT, 32'h8000_0000, 32'h8000_0000);
    send_op(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_capacity(CAP_PLAN[p]);
      calm = (p == PHASES - 1);
      random_phase(CAP_PLAN[p], 150, p == 2);
      drain();
    end

    $display("run covered %0d items, %0d hits, over %0d capacity settings (0, 1, 16, 31 among them)",
             items_sent, hit_count, PHASES + 1);
    $display("incl. extreme keys/values, evictions after lowering capacity, a long output stall");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
